### rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_HALF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COND_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

  // configuration reset values
  localparam logic [15:0] BIT_HALF_RST    = 16'd100;
  localparam logic [15:0] COND_HOLD_RST   = 16'd200;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  // bits in one byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [15:0] bit_half;
    logic [15:0] cond_hold;
    logic [15:0] ack_timeout;
  } timing_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } result_t;

endpackage

### rtl/i2cmbe_in_if.sv
// ----------------------------------------------------------------------------
// i2cmbe_in_if
// Input channel: one tick item with optional command and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, command, tx_byte, send_ack, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, command, tx_byte, send_ack, sda_in,
                  output ready);
endinterface

### rtl/i2cmbe_out_if.sv
// ----------------------------------------------------------------------------
// i2cmbe_out_if
// Result channel: bus line levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res,
                         rx_byte, ack_error,
                  input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res,
                        rx_byte, ack_error,
                  output ready);
endinterface

### rtl/i2cmbe_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cmbe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cmbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/i2cmbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cmbe_cfg_regs
// Timing configuration registers, always ready for a write.
// ----------------------------------------------------------------------------
module i2cmbe_cfg_regs
  import i2cmbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  i2cmbe_cfg_if.sink        cfg_ch,
  output timing_t           timing
);

  timing_t timing_r;
  timing_t timing_nxt;

  assign cfg_ch.ready = 1'b1;
  assign timing       = timing_r;

  // write decode, unknown indexes are dropped
  always_comb begin
    timing_nxt = timing_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BIT_HALF:    timing_nxt.bit_half    = cfg_ch.data;
        CFG_COND_HOLD:   timing_nxt.cond_hold   = cfg_ch.data;
        CFG_ACK_TIMEOUT: timing_nxt.ack_timeout = cfg_ch.data;
        default:         timing_nxt = timing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.bit_half    <= BIT_HALF_RST;
      timing_r.cond_hold   <= COND_HOLD_RST;
      timing_r.ack_timeout <= ACK_TIMEOUT_RST;
    end else begin
      timing_r <= timing_nxt;
    end
  end

endmodule

### rtl/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus phase sequencer: advances one tick per accepted item and forms the
// line levels and status of that tick.
// ----------------------------------------------------------------------------
module i2cmbe_core
  import i2cmbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  item_t    item,
  input  timing_t  timing,
  output result_t  res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI,
    PH_WR_SET, PH_WR_HIGH, PH_WR_LOW,
    PH_AK_SET, PH_AK_HIGH, PH_AK_POLL,
    PH_RD_LOW, PH_RD_HIGH, PH_RA_SET, PH_RA_HIGH
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic        error_r, error_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;

  logic        done;
  logic        enter_en;
  phase_t      enter_ph;
  logic [15:0] tick_inc;
  logic [15:0] phase_len;
  logic [3:0]  bit_inc;

  assign tick_inc = tick_count_r + 16'd1;
  assign bit_inc  = bit_count_r + 4'd1;

  // start and stop phases use the condition hold time
  always_comb begin
    if (phase_r inside {PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI}) begin
      phase_len = timing.cond_hold;
    end else begin
      phase_len = timing.bit_half;
    end
  end

  // next state for one tick
  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    tick_count_nxt = tick_count_r;
    wait_count_nxt = wait_count_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    error_nxt      = error_r;
    rx_hold_nxt    = rx_hold_r;
    done           = 1'b0;
    enter_en       = 1'b0;
    enter_ph       = PH_IDLE;

    // phase transitions
    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        bit_count_nxt = 4'd0;
        case (item.command)
          CMD_START: begin
            enter_en = 1'b1;
            enter_ph = PH_ST_HI;
          end
          CMD_STOP: begin
            enter_en = 1'b1;
            enter_ph = PH_SP_LO;
          end
          CMD_WRITE: begin
            shift_nxt = item.tx_byte;
            enter_en  = 1'b1;
            enter_ph  = PH_WR_SET;
          end
          CMD_WAIT: begin
            error_nxt = 1'b0;
            enter_en  = 1'b1;
            enter_ph  = PH_AK_SET;
          end
          CMD_READ: begin
            shift_nxt      = 8'd0;
            ack_choice_nxt = item.send_ack;
            enter_en       = 1'b1;
            enter_ph       = PH_RD_LOW;
          end
          default: ;
        endcase
      end
    end else if (phase_r == PH_AK_POLL) begin
      if (!item.sda_in) begin
        scl_nxt        = 1'b0;
        phase_nxt      = PH_IDLE;
        tick_count_nxt = 16'd0;
        done           = 1'b1;
      end else if (wait_count_r >= timing.ack_timeout) begin
        error_nxt = 1'b1;
        enter_en  = 1'b1;
        enter_ph  = PH_SP_LO;
      end else begin
        wait_count_nxt = wait_count_r + 16'd1;
      end
    end else begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= phase_len) begin
        case (phase_r)
          PH_ST_HI: begin
            enter_en = 1'b1;
            enter_ph = PH_ST_LO;
          end
          PH_ST_LO: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
          PH_SP_LO: begin
            enter_en = 1'b1;
            enter_ph = PH_SP_HI;
          end
          PH_WR_SET: begin
            enter_en = 1'b1;
            enter_ph = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            enter_en = 1'b1;
            enter_ph = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            shift_nxt     = {shift_r[6:0], 1'b0};
            bit_count_nxt = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
              done = 1'b1;
            end else begin
              enter_en = 1'b1;
              enter_ph = PH_WR_SET;
            end
          end
          PH_AK_SET: begin
            enter_en = 1'b1;
            enter_ph = PH_AK_HIGH;
          end
          PH_AK_HIGH: begin
            enter_en = 1'b1;
            enter_ph = PH_AK_POLL;
          end
          PH_RD_LOW: begin
            enter_en = 1'b1;
            enter_ph = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            bit_count_nxt = bit_inc;
            enter_en      = 1'b1;
            if (bit_inc >= BYTE_BITS) begin
              rx_hold_nxt = shift_r;
              enter_ph    = PH_RA_SET;
            end else begin
              enter_ph    = PH_RD_LOW;
            end
          end
          PH_RA_SET: begin
            enter_en = 1'b1;
            enter_ph = PH_RA_HIGH;
          end
          PH_RA_HIGH: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          phase_nxt      = PH_IDLE;
          tick_count_nxt = 16'd0;
        end
      end
    end

    // line setup on entry to a phase
    if (enter_en) begin
      phase_nxt      = enter_ph;
      tick_count_nxt = 16'd0;
      case (enter_ph)
        PH_ST_HI: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_ST_LO: sda_nxt = 1'b1;
        PH_SP_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        PH_SP_HI: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_WR_SET: begin
          scl_nxt = 1'b0;
          sda_nxt = ~shift_nxt[7];
        end
        PH_WR_HIGH: scl_nxt = 1'b1;
        PH_WR_LOW:  scl_nxt = 1'b0;
        PH_AK_SET:  sda_nxt = 1'b0;
        PH_AK_HIGH: scl_nxt = 1'b1;
        PH_AK_POLL: wait_count_nxt = 16'd0;
        PH_RD_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        PH_RD_HIGH: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_nxt[6:0], item.sda_in};
        end
        PH_RA_SET: begin
          scl_nxt = 1'b0;
          sda_nxt = ack_choice_nxt;
        end
        PH_RA_HIGH: scl_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  // result of this tick, taken from the updated state
  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_pull_low = sda_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = rx_hold_nxt;
    res.ack_error    = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      tick_count_r <= 16'd0;
      wait_count_r <= 16'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b0;
      ack_choice_r <= 1'b0;
      error_r      <= 1'b0;
      rx_hold_r    <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      tick_count_r <= tick_count_nxt;
      wait_count_r <= wait_count_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_choice_r <= ack_choice_nxt;
      error_r      <= error_nxt;
      rx_hold_r    <= rx_hold_nxt;
    end
  end

endmodule

### rtl/i2cmbe_out_reg.sv
// ----------------------------------------------------------------------------
// i2cmbe_out_reg
// Result register with valid flag; holds the input side off while a result
// waits to be taken and is not being drained.
// ----------------------------------------------------------------------------
module i2cmbe_out_reg
  import i2cmbe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  result_t       res,
  output logic          can_load,
  i2cmbe_out_if.source  out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // room when empty or when the held result leaves this cycle
  assign can_load  = ~valid_r | out_ch.ready;
  assign valid_nxt = load | (valid_r & ~out_ch.ready);

  assign out_ch.valid        = valid_r;
  assign out_ch.scl_level    = data_r.scl_level;
  assign out_ch.sda_pull_low = data_r.sda_pull_low;
  assign out_ch.busy_res     = data_r.busy_res;
  assign out_ch.done_res     = data_r.done_res;
  assign out_ch.rx_byte      = data_r.rx_byte;
  assign out_ch.ack_error    = data_r.ack_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

### rtl/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// I2C master byte engine: start, stop, byte write, ack wait and byte read
// sequenced one bus tick per item.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      cmd_valid, command, tx_byte, send_ack, sda_in
//   out_ch   out  valid / ready      scl_level, sda_pull_low, busy_res, done_res,
//                                    rx_byte, ack_error
//   cfg_ch   in   valid / ready (=1) index, data
//
// The phase sequencer updates on acceptance of an item and its result is
// held in the output register, presented in the cycle after acceptance.
// A new item is accepted every cycle while the output register is empty or
// being drained; a stalled output holds the input off only that long.
// Reset (rst_n low, synchronous) returns the sequencer to idle with SCL
// high and SDA released, and loads the default timing values.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top
  import i2cmbe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  i2cmbe_in_if.sink     in_ch,
  i2cmbe_out_if.source  out_ch,
  i2cmbe_cfg_if.sink    cfg_ch
);

  timing_t timing;
  item_t   item;
  result_t res;
  logic    can_load;
  logic    step;

  // input handshake
  assign in_ch.ready = can_load;
  assign step        = in_ch.valid & can_load;

  assign item.cmd_valid = in_ch.cmd_valid;
  assign item.command   = in_ch.command;
  assign item.tx_byte   = in_ch.tx_byte;
  assign item.send_ack  = in_ch.send_ack;
  assign item.sda_in    = in_ch.sda_in;

  i2cmbe_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .timing (timing)
  );

  i2cmbe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .timing (timing),
    .res    (res)
  );

  i2cmbe_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte engine. Each item is one bus
// tick. A cycle-exact engine model predicts the line levels and status of
// every tick, and each accepted result is checked in order against it. A
// short table of directed ticks comes first, then command sequences with
// random content under several timing settings, from zero and one tick up
// to the largest ack timeout. Both channel sides pause at random.
// ----------------------------------------------------------------------------
module tb;
  import i2cmbe_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SHOW_MAX     = 10;

  // codes the engine must ignore
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  // line levels of an idle engine straight out of reset
  localparam result_t IDLE_RES = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b0,
                                   done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b0};
  // first tick of a start condition: both lines still released
  localparam result_t START_RES = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b1,
                                    done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b0};

  typedef enum logic [3:0] {
    EP_IDLE, EP_START_HI, EP_START_LO, EP_STOP_LO, EP_STOP_HI,
    EP_WR_SET, EP_WR_HIGH, EP_WR_LOW, EP_ACK_SET, EP_ACK_HIGH, EP_ACK_POLL,
    EP_RD_LOW, EP_RD_HIGH, EP_RA_SET, EP_RA_HIGH
  } eng_phase_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [15:0]      reg_val;
    item_t            tick;
    int               reps;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  i2cmbe_in_if  in_if();
  i2cmbe_out_if out_if();
  i2cmbe_cfg_if cfg_if();

  i2c_master_byte_engine_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // engine model state
  timing_t    timing;
  eng_phase_t ph;
  logic [2:0] act_cmd;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [15:0] tick_cnt;
  logic [15:0] poll_cnt;
  logic       scl_q;
  logic       sda_q;
  logic       ack_sel;
  logic       err_q;
  logic [7:0] rx_q;

  result_t    bus_levels_q[$];
  dir_row_t   dir_rows[$];
  int         mismatch_cnt = 0;
  int         ticks_sent = 0;
  bit         pace_on = 1'b1;

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // run limit
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void reset_model();
    timing.bit_half    = BIT_HALF_RST;
    timing.cond_hold   = COND_HOLD_RST;
    timing.ack_timeout = ACK_TIMEOUT_RST;
    ph       = EP_IDLE;
    act_cmd  = CMD_START;
    bit_cnt  = '0;
    shreg    = '0;
    tick_cnt = '0;
    poll_cnt = '0;
    scl_q    = 1'b1;
    sda_q    = 1'b0;
    ack_sel  = 1'b0;
    err_q    = 1'b0;
    rx_q     = '0;
  endfunction

  // start and stop phases use the condition hold, the rest the bit half
  function automatic logic [15:0] phase_len();
    case (ph)
      EP_START_HI, EP_START_LO, EP_STOP_LO, EP_STOP_HI: return timing.cond_hold;
      default: return timing.bit_half;
    endcase
  endfunction

  function automatic void enter_phase(eng_phase_t p, logic sda);
    ph       = p;
    tick_cnt = '0;
    case (p)
      EP_START_HI: begin scl_q = 1'b1; sda_q = 1'b0; end
      EP_START_LO: sda_q = 1'b1;
      EP_STOP_LO:  begin scl_q = 1'b0; sda_q = 1'b1; end
      EP_STOP_HI:  begin scl_q = 1'b1; sda_q = 1'b0; end
      EP_WR_SET:   begin scl_q = 1'b0; sda_q = ~shreg[7]; end
      EP_WR_HIGH:  scl_q = 1'b1;
      EP_WR_LOW:   scl_q = 1'b0;
      EP_ACK_SET:  sda_q = 1'b0;
      EP_ACK_HIGH: scl_q = 1'b1;
      EP_ACK_POLL: poll_cnt = '0;
      EP_RD_LOW:   begin scl_q = 1'b0; sda_q = 1'b0; end
      EP_RD_HIGH:  begin scl_q = 1'b1; shreg = {shreg[6:0], sda}; end
      EP_RA_SET:   begin scl_q = 1'b0; sda_q = ack_sel; end
      EP_RA_HIGH:  scl_q = 1'b1;
      default: ;
    endcase
  endfunction

  // end of a timed phase, returns 1 when the command completes
  function automatic logic advance_phase(logic sda);
    case (ph)
      EP_START_HI: enter_phase(EP_START_LO, sda);
      EP_START_LO: begin scl_q = 1'b0; ph = EP_IDLE; tick_cnt = '0; return 1'b1; end
      EP_STOP_LO:  enter_phase(EP_STOP_HI, sda);
      EP_WR_SET:   enter_phase(EP_WR_HIGH, sda);
      EP_WR_HIGH:  enter_phase(EP_WR_LOW, sda);
      EP_WR_LOW: begin
        shreg   = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BYTE_BITS) begin
          ph = EP_IDLE; tick_cnt = '0; return 1'b1;
        end
        enter_phase(EP_WR_SET, sda);
      end
      EP_ACK_SET:  enter_phase(EP_ACK_HIGH, sda);
      EP_ACK_HIGH: enter_phase(EP_ACK_POLL, sda);
      EP_RD_LOW:   enter_phase(EP_RD_HIGH, sda);
      EP_RD_HIGH: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BYTE_BITS) begin
          rx_q = shreg;
          enter_phase(EP_RA_SET, sda);
        end else begin
          enter_phase(EP_RD_LOW, sda);
        end
      end
      EP_RA_SET:   enter_phase(EP_RA_HIGH, sda);
      EP_RA_HIGH:  begin scl_q = 1'b0; ph = EP_IDLE; tick_cnt = '0; return 1'b1; end
      default:     begin ph = EP_IDLE; tick_cnt = '0; return 1'b1; end
    endcase
    return 1'b0;
  endfunction

  // one bus tick of the engine
  function automatic result_t engine_tick(item_t t);
    result_t r;
    logic    done;
    done = 1'b0;
    if (ph == EP_IDLE) begin
      if (t.cmd_valid) begin
        bit_cnt = '0;
        case (t.command)
          CMD_START: begin act_cmd = t.command; enter_phase(EP_START_HI, t.sda_in); end
          CMD_STOP:  begin act_cmd = t.command; enter_phase(EP_STOP_LO, t.sda_in); end
          CMD_WRITE: begin
            act_cmd = t.command;
            shreg   = t.tx_byte;
            enter_phase(EP_WR_SET, t.sda_in);
          end
          CMD_WAIT: begin
            act_cmd = t.command;
            err_q   = 1'b0;
            enter_phase(EP_ACK_SET, t.sda_in);
          end
          CMD_READ: begin
            act_cmd = t.command;
            shreg   = '0;
            ack_sel = t.send_ack;
            enter_phase(EP_RD_LOW, t.sda_in);
          end
          default: ;
        endcase
      end
    end else if (ph == EP_ACK_POLL) begin
      if (!t.sda_in) begin
        scl_q = 1'b0; ph = EP_IDLE; tick_cnt = '0; done = 1'b1;
      end else if (poll_cnt >= timing.ack_timeout) begin
        // slave never answered: flag it and release the bus with a stop
        err_q = 1'b1;
        enter_phase(EP_STOP_LO, t.sda_in);
      end else begin
        poll_cnt = poll_cnt + 16'd1;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= phase_len()) done = advance_phase(t.sda_in);
    end
    r.scl_level    = scl_q;
    r.sda_pull_low = sda_q;
    r.busy_res     = (ph != EP_IDLE);
    r.done_res     = done;
    r.rx_byte      = rx_q;
    r.ack_error    = err_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one tick item, record its expected levels once accepted
  task automatic send_tick(item_t t, bit typed, result_t want);
    int      gap;
    result_t got;
    gap = pace_on ? int'($urandom_range(0, 7)) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.cmd_valid <= t.cmd_valid;
    in_if.command   <= t.command;
    in_if.tx_byte   <= t.tx_byte;
    in_if.send_ack  <= t.send_ack;
    in_if.sda_in    <= t.sda_in;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    got = engine_tick(t);
    bus_levels_q.push_back(typed ? want : got);
    ticks_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_BIT_HALF:    timing.bit_half    = val;
      CFG_COND_HOLD:   timing.cond_hold   = val;
      CFG_ACK_TIMEOUT: timing.ack_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // finish any command, then let every result drain
  task automatic settle();
    item_t t;
    t = '0;
    while (ph != EP_IDLE) send_tick(t, 1'b0, '0);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(logic [15:0] bh, logic [15:0] ch, logic [15:0] at);
    settle();
    write_reg(CFG_BIT_HALF, bh);
    write_reg(CFG_COND_HOLD, ch);
    write_reg(CFG_ACK_TIMEOUT, at);
  endtask

  // one command with random content; the slave acks after ack_after polls
  task automatic run_command(logic [2:0] cmd, int ack_after);
    item_t t;
    int    polls;
    t.cmd_valid = 1'b1;
    t.command   = cmd;
    t.tx_byte   = 8'($urandom);
    t.send_ack  = 1'($urandom);
    t.sda_in    = 1'($urandom);
    send_tick(t, 1'b0, '0);
    polls = 0;
    while (ph != EP_IDLE) begin
      // commands offered while busy must be ignored
      t.cmd_valid = ($urandom_range(0, 3) == 0);
      t.command   = 3'($urandom);
      t.tx_byte   = 8'($urandom);
      t.send_ack  = 1'($urandom);
      if (ph == EP_ACK_POLL) begin
        t.sda_in = (polls < ack_after);
        polls++;
      end else begin
        t.sda_in = 1'($urandom);
      end
      send_tick(t, 1'b0, '0);
    end
  endtask

  task automatic run_traffic(int budget);
    int    first;
    item_t t;
    first = ticks_sent;
    while (ticks_sent - first < budget) begin
      // idle or unknown-code noise between commands
      if ($urandom_range(0, 4) == 0) begin
        t.cmd_valid = 1'($urandom);
        t.command   = t.cmd_valid ? 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI))
                                  : 3'($urandom);
        t.tx_byte   = 8'($urandom);
        t.send_ack  = 1'($urandom);
        t.sda_in    = 1'($urandom);
        send_tick(t, 1'b0, '0);
      end
      run_command(3'($urandom_range(CMD_START, CMD_READ)),
                  $urandom_range(0, int'(timing.ack_timeout) + 1));
    end
  endtask

  function automatic dir_row_t tick_row(logic cv, logic [2:0] cmd, logic [7:0] tx,
                                        logic ack, logic sda, int reps,
                                        bit typed = 1'b0, result_t want = '0);
    dir_row_t r;
    r.kind    = ROW_TICK;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.tick    = '{cmd_valid: cv, command: cmd, tx_byte: tx, send_ack: ack, sda_in: sda};
    r.reps    = reps;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    dir_row_t r;
    r         = tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b0, 0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  // result ready with a random stall per item
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = pace_on ? int'($urandom_range(0, 7)) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1 || rst_n !== 1'b1);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.scl_level    = out_if.scl_level;
      got.sda_pull_low = out_if.sda_pull_low;
      got.busy_res     = out_if.busy_res;
      got.done_res     = out_if.done_res;
      got.rx_byte      = out_if.rx_byte;
      got.ack_error    = out_if.ack_error;
      if (bus_levels_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= SHOW_MAX)
          $display("unexpected item: scl=%b sda_low=%b busy=%b done=%b rx=%h err=%b",
                   got.scl_level, got.sda_pull_low, got.busy_res, got.done_res,
                   got.rx_byte, got.ack_error);
      end else begin
        want = bus_levels_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX) begin
            $display("mismatch exp: scl=%b sda_low=%b busy=%b done=%b rx=%h err=%b",
                     want.scl_level, want.sda_pull_low, want.busy_res, want.done_res,
                     want.rx_byte, want.ack_error);
            $display("         got: scl=%b sda_low=%b busy=%b done=%b rx=%h err=%b",
                     got.scl_level, got.sda_pull_low, got.busy_res, got.done_res,
                     got.rx_byte, got.ack_error);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd_valid = 1'b0;
    in_if.command   = CMD_START;
    in_if.tx_byte   = '0;
    in_if.send_ack  = 1'b0;
    in_if.sda_in    = 1'b1;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_BIT_HALF;
    cfg_if.data     = '0;
    reset_model();

    // directed table: idle and unknown codes at reset timing, then each
    // command at short timing, busy offers, ack and timeout, zero bit half
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 2, 1'b1, IDLE_RES));
    dir_rows.push_back(tick_row(1'b1, CMD_BAD_LO, 8'h00, 1'b0, 1'b1, 1, 1'b1, IDLE_RES));
    dir_rows.push_back(tick_row(1'b1, CMD_BAD_HI, 8'hFF, 1'b1, 1'b0, 1, 1'b1, IDLE_RES));
    dir_rows.push_back(cfg_row(CFG_BIT_HALF, 16'd1));
    dir_rows.push_back(cfg_row(CFG_COND_HOLD, 16'd1));
    dir_rows.push_back(cfg_row(CFG_ACK_TIMEOUT, 16'd2));
    dir_rows.push_back(tick_row(1'b1, CMD_START, 8'h00, 1'b0, 1'b1, 1, 1'b1, START_RES));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 3));
    dir_rows.push_back(tick_row(1'b1, CMD_WRITE, 8'hA5, 1'b0, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b1, CMD_STOP, 8'h5A, 1'b1, 1'b1, 30));
    dir_rows.push_back(tick_row(1'b0, CMD_STOP, 8'h00, 1'b0, 1'b1, 4));
    dir_rows.push_back(tick_row(1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b0, 26));
    dir_rows.push_back(tick_row(1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 26));
    dir_rows.push_back(tick_row(1'b1, CMD_WAIT, 8'h00, 1'b0, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 3));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b0, 2));
    dir_rows.push_back(tick_row(1'b1, CMD_WAIT, 8'h00, 1'b0, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 12));
    dir_rows.push_back(tick_row(1'b1, CMD_READ, 8'h00, 1'b1, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 20));
    dir_rows.push_back(tick_row(1'b1, CMD_READ, 8'hFF, 1'b0, 1'b0, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b0, 20));
    dir_rows.push_back(cfg_row(CFG_BIT_HALF, 16'd0));
    dir_rows.push_back(tick_row(1'b1, CMD_WRITE, 8'h3C, 1'b0, 1'b1, 1));
    dir_rows.push_back(tick_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 26));

    // reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        repeat (dir_rows[i].reps)
          send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random sequences under several timings
    set_timing(16'd1, 16'd1, 16'd1);
    run_traffic(300);
    set_timing(16'd2, 16'd3, 16'd4);
    run_traffic(250);
    set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
               16'($urandom_range(1, 8)));
    run_traffic(250);
    // zero ack timeout: the first high poll already fails
    set_timing(16'd3, 16'd1, 16'd0);
    run_traffic(250);

    // largest ack timeout: the slave answers after a few polls, then at once
    set_timing(16'd2, 16'd2, 16'hFFFF);
    run_command(CMD_WAIT, 3);
    run_command(CMD_WAIT, 0);

    settle();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
